[sv/assert_macros.svh]
// Assertion helpers, sampled on the rising clock edge and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ted_pkg.sv]
`timescale 1ns / 1ps
package ted_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int COORD_FRAC_BITS = 8;
   localparam int WEIGHT_WIDTH    = 25;

   localparam int REQ_TDATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((WEIGHT_WIDTH + 7) / 8) * 8;

   // squaring split into halves
   localparam int LO_W  = (COORD_WIDTH + 1) / 2;
   localparam int HI_W  = COORD_WIDTH - LO_W;
   localparam int SQ_W  = 2 * COORD_WIDTH;
   localparam int SUM_W = SQ_W + 1;
   localparam int FRAC2 = 2 * COORD_FRAC_BITS;
   localparam int T_W   = SUM_W - FRAC2;

   localparam logic [SUM_W-1:0] FRAC_MASK = ~({SUM_W{1'b1}} << FRAC2);

   // divide by ten, several quotient bits per stage
   localparam int DIV_STEP   = 8;
   localparam int DIV_STAGES = (T_W + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_W      = DIV_STAGES * DIV_STEP;
   localparam int DREM_W     = 4;
   localparam logic [DREM_W:0] ATT_DIVISOR = 5'd10;

   // square root, one root bit per stage
   localparam int ROOT_W = COORD_WIDTH + 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;
   localparam int POST_W = ROOT_W + 1;
   localparam int CMP_W  = (POST_W > WEIGHT_WIDTH) ? POST_W : WEIGHT_WIDTH;

   localparam logic [POST_W-1:0] ROUND_ADD =
      {{(POST_W-1){1'b0}}, 1'b1} << COORD_FRAC_BITS;
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = '1;

   typedef enum logic [1:0] {
      MODE_ROUND = 2'd0,
      MODE_CEIL  = 2'd1,
      MODE_ATT   = 2'd2
   } dist_mode_type;

   typedef struct packed {
      logic [DIV_W-1:0]  t;
      logic [SUM_W-1:0]  s;
      logic [DIV_W-1:0]  q;
      logic [DREM_W-1:0] r;
      dist_mode_type     mode;
   } div_stage_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
      dist_mode_type     mode;
   } root_stage_type;

endpackage

[sv/tsp_edge_distance_unit.sv]
// Throughput: one transaction per cycle while the skid register is empty.
// The square root is a 34-stage pipeline, one root bit per stage, preceded by
// a 7-stage divide-by-ten for ATT mode (32-bit coordinates).
// Output register plus skid register; req_tready drops only while the skid is full.
// Reset (synchronous, active high) clears all valid bits and sets the mode to rounded.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsp_edge_distance_unit
   import ted_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // first_x, first_y, second_x, second_y
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // edge_weight, zero padded
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   dist_mode_type mode_ff;

   logic pipe_en;
   logic out_go;

   logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y;
   logic [COORD_WIDTH:0]   diff_x, diff_y, neg_x, neg_y;
   logic [COORD_WIDTH-1:0] dx_in, dy_in;
   logic [COORD_WIDTH-1:0] dx_ff, dy_ff;
   dist_mode_type          mode1_ff, mode2_ff, mode3_ff, mode4_ff;
   logic                   v1_ff, v2_ff, v3_ff, v4_ff;

   logic [SQ_W-1:0]       pxhh, pxhl, pxll, pyhh, pyhl, pyll;
   logic [2*HI_W-1:0]     xhh_ff, yhh_ff;
   logic [HI_W+LO_W-1:0]  xhl_ff, yhl_ff;
   logic [2*LO_W-1:0]     xll_ff, yll_ff;

   logic [SQ_W-1:0]  xsq_in, ysq_in, xsq_ff, ysq_ff;
   logic [SUM_W-1:0] s_ff;
   logic [SUM_W-1:0] s_shr;
   div_stage_type    div0_in;

   div_stage_type  div_ff [0:DIV_STAGES];
   logic [DIV_STAGES:0] div_v_ff;

   logic [DIV_W-1:0] q_ceil;
   root_stage_type   rad_in;
   root_stage_type   sq_ff [0:ROOT_W];
   logic [ROOT_W:0]  sq_v_ff;

   logic [POST_W-1:0]       post_wide;
   logic [CMP_W-1:0]        post_ext;
   logic [WEIGHT_WIDTH-1:0] post_w_in, post_w_ff;
   logic                    post_v_ff;

   logic                    rsp_v_in, rsp_v_ff, skid_v_in, skid_v_ff;
   logic [WEIGHT_WIDTH-1:0] rsp_w_in, rsp_w_ff, skid_w_in, skid_w_ff;

   assign csr_ready  = 1'b1;
   assign pipe_en    = ~skid_v_ff;
   assign req_tready = pipe_en;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_w_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ROUND;
      end else if (csr_valid) begin
         mode_ff <= dist_mode_type'(csr_wdata);
      end
   end

   // stage 1: absolute differences
   always_comb begin
      first_x  = req_tdata[COORD_WIDTH-1:0];
      first_y  = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      second_x = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
      second_y = req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];
      diff_x   = {first_x[COORD_WIDTH-1], first_x} - {second_x[COORD_WIDTH-1], second_x};
      diff_y   = {first_y[COORD_WIDTH-1], first_y} - {second_y[COORD_WIDTH-1], second_y};
      neg_x    = ~diff_x + 1'b1;
      neg_y    = ~diff_y + 1'b1;
      dx_in    = diff_x[COORD_WIDTH] ? neg_x[COORD_WIDTH-1:0] : diff_x[COORD_WIDTH-1:0];
      dy_in    = diff_y[COORD_WIDTH] ? neg_y[COORD_WIDTH-1:0] : diff_y[COORD_WIDTH-1:0];
   end

   // stage 2: partial products
   always_comb begin
      pxhh = SQ_W'(dx_ff[COORD_WIDTH-1:LO_W]) * SQ_W'(dx_ff[COORD_WIDTH-1:LO_W]);
      pxhl = SQ_W'(dx_ff[COORD_WIDTH-1:LO_W]) * SQ_W'(dx_ff[LO_W-1:0]);
      pxll = SQ_W'(dx_ff[LO_W-1:0]) * SQ_W'(dx_ff[LO_W-1:0]);
      pyhh = SQ_W'(dy_ff[COORD_WIDTH-1:LO_W]) * SQ_W'(dy_ff[COORD_WIDTH-1:LO_W]);
      pyhl = SQ_W'(dy_ff[COORD_WIDTH-1:LO_W]) * SQ_W'(dy_ff[LO_W-1:0]);
      pyll = SQ_W'(dy_ff[LO_W-1:0]) * SQ_W'(dy_ff[LO_W-1:0]);
   end

   // stage 3: squares
   always_comb begin
      xsq_in = (SQ_W'(xhh_ff) << (2 * LO_W)) + (SQ_W'(xhl_ff) << (LO_W + 1)) + SQ_W'(xll_ff);
      ysq_in = (SQ_W'(yhh_ff) << (2 * LO_W)) + (SQ_W'(yhl_ff) << (LO_W + 1)) + SQ_W'(yll_ff);
   end

   // stage 5 input: ceil(S / 2^2F)
   always_comb begin
      s_shr     = s_ff >> FRAC2;
      div0_in.t = DIV_W'(s_shr) + DIV_W'(|(s_ff & FRAC_MASK));
      div0_in.s = s_ff;
      div0_in.q = '0;
      div0_in.r = '0;
      div0_in.mode = mode4_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         mode1_ff <= mode_ff;
         xhh_ff   <= pxhh[2*HI_W-1:0];
         xhl_ff   <= pxhl[HI_W+LO_W-1:0];
         xll_ff   <= pxll[2*LO_W-1:0];
         yhh_ff   <= pyhh[2*HI_W-1:0];
         yhl_ff   <= pyhl[HI_W+LO_W-1:0];
         yll_ff   <= pyll[2*LO_W-1:0];
         mode2_ff <= mode1_ff;
         xsq_ff   <= xsq_in;
         ysq_ff   <= ysq_in;
         mode3_ff <= mode2_ff;
         s_ff     <= SUM_W'(xsq_ff) + SUM_W'(ysq_ff);
         mode4_ff <= mode3_ff;
         div_ff[0] <= div0_in;
         sq_ff[0]  <= rad_in;
         post_w_ff <= post_w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         div_v_ff  <= '0;
         sq_v_ff   <= '0;
         post_v_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff     <= req_tvalid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         div_v_ff  <= {div_v_ff[DIV_STAGES-1:0], v4_ff};
         sq_v_ff   <= {sq_v_ff[ROOT_W-1:0], div_v_ff[DIV_STAGES]};
         post_v_ff <= sq_v_ff[ROOT_W];
      end
   end

   // restoring division by ten, DIV_STEP quotient bits per stage
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [DREM_W:0]   part;
      logic [DREM_W-1:0] r;
      logic [DIV_W-1:0]  q;
      div_stage_type     nx;

      always_comb begin
         r = div_ff[k].r;
         q = div_ff[k].q;
         for (int b = 0; b < DIV_STEP; b++) begin
            part = {r, div_ff[k].t[DIV_W-1-DIV_STEP*k-b]};
            if (part >= ATT_DIVISOR) begin
               part = part - ATT_DIVISOR;
               q    = {q[DIV_W-2:0], 1'b1};
            end else begin
               q    = {q[DIV_W-2:0], 1'b0};
            end
            r = part[DREM_W-1:0];
         end
         nx   = div_ff[k];
         nx.q = q;
         nx.r = r;
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            div_ff[k+1] <= nx;
         end
      end
   end

   // radicand select
   always_comb begin
      q_ceil      = div_ff[DIV_STAGES].q + DIV_W'(|div_ff[DIV_STAGES].r);
      rad_in.root = '0;
      rad_in.rem  = '0;
      rad_in.mode = div_ff[DIV_STAGES].mode;
      case (div_ff[DIV_STAGES].mode)
         MODE_CEIL: rad_in.rad = RAD_W'(div_ff[DIV_STAGES].t);
         MODE_ATT:  rad_in.rad = RAD_W'(q_ceil);
         default:   rad_in.rad = RAD_W'(div_ff[DIV_STAGES].s) << 2;
      endcase
   end

   // integer square root, one root bit per stage
   for (genvar i = 0; i < ROOT_W; i++) begin : g_root
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      root_stage_type   nx;

      always_comb begin
         cur   = {sq_ff[i].rem[REM_W-3:0], sq_ff[i].rad[RAD_W-1 -: 2]};
         trial = {1'b0, sq_ff[i].root, 2'b01};
         nx      = sq_ff[i];
         nx.rad  = sq_ff[i].rad << 2;
         if (cur >= trial) begin
            nx.rem  = cur - trial;
            nx.root = {sq_ff[i].root[ROOT_W-2:0], 1'b1};
         end else begin
            nx.rem  = cur;
            nx.root = {sq_ff[i].root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            sq_ff[i+1] <= nx;
         end
      end
   end

   // final rounding and saturation
   always_comb begin
      case (sq_ff[ROOT_W].mode) inside
         MODE_CEIL, MODE_ATT:
            post_wide = POST_W'(sq_ff[ROOT_W].root) + POST_W'(|sq_ff[ROOT_W].rem);
         default:
            post_wide = (POST_W'(sq_ff[ROOT_W].root) + ROUND_ADD) >> (COORD_FRAC_BITS + 1);
      endcase
      post_ext = CMP_W'(post_wide);
      if (post_ext > CMP_W'(WEIGHT_MAX)) begin
         post_w_in = WEIGHT_MAX;
      end else begin
         post_w_in = post_ext[WEIGHT_WIDTH-1:0];
      end
   end

   // output register with skid
   always_comb begin
      out_go    = rsp_v_ff & rsp_tready;
      rsp_v_in  = rsp_v_ff;
      rsp_w_in  = rsp_w_ff;
      skid_v_in = skid_v_ff;
      skid_w_in = skid_w_ff;
      if (skid_v_ff) begin
         if (out_go) begin
            rsp_w_in  = skid_w_ff;
            skid_v_in = 1'b0;
         end
      end else if (!rsp_v_ff || out_go) begin
         rsp_v_in = post_v_ff;
         rsp_w_in = post_w_ff;
      end else begin
         skid_v_in = post_v_ff;
         skid_w_in = post_w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_w_ff  <= rsp_w_in;
      skid_w_ff <= skid_w_in;
   end

   `ASSERT_IMPL(a_skid_behind_rsp, skid_v_ff, rsp_v_ff, "skid full with output register empty")
   `ASSERT_NEXT(a_skid_catches, rsp_v_ff && !rsp_tready && !skid_v_ff && post_v_ff, skid_v_ff, "stalled transaction lost")
   `ASSERT_IMPL(a_div_rem, div_v_ff[DIV_STAGES], div_ff[DIV_STAGES].r < ATT_DIVISOR, "divide remainder out of range")
   `ASSERT_IMPL(a_root_rem, sq_v_ff[ROOT_W], sq_ff[ROOT_W].rem <= (REM_W'(sq_ff[ROOT_W].root) << 1), "square root remainder too large")

endmodule

[tb/sv/tsp_edge_distance_unit_tb.sv]
`timescale 1ns / 1ps
module tsp_edge_distance_unit_tb
   import ted_pkg::*;
();

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int N_DIRECTED = 21;
   localparam int N_PHASES = 6;
   localparam int PHASE_ITEMS = 240;
   localparam int ATT_SCALE = 10;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD = 600;
   localparam int HOLD_AT_RESULT = 300;
   localparam int CYCLE_LIMIT = 300000;

   localparam logic [COORD_WIDTH-1:0] C_MIN = 32'h8000_0000;
   localparam logic [COORD_WIDTH-1:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_WIDTH-1:0] C_3 = 32'd768;
   localparam logic [COORD_WIDTH-1:0] C_4 = 32'd1024;
   localparam logic [COORD_WIDTH-1:0] C_NEG3 = -32'sd768;
   localparam logic [COORD_WIDTH-1:0] C_NEG4 = -32'sd1024;
   localparam logic [COORD_WIDTH-1:0] C_HALF = 32'd128;
   localparam logic [COORD_WIDTH-1:0] C_ULP = 32'd1;
   localparam logic [COORD_WIDTH-1:0] C_TEN = 32'd2560;

   typedef struct {
      logic [1:0]              mode;
      logic [COORD_WIDTH-1:0]  ax;
      logic [COORD_WIDTH-1:0]  ay;
      logic [COORD_WIDTH-1:0]  bx;
      logic [COORD_WIDTH-1:0]  by;
      bit                      known;
      logic [WEIGHT_WIDTH-1:0] weight;
   } pair_row_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_wdata = 2'd0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [WEIGHT_WIDTH-1:0] weight_queue [$];
   logic [1:0] cur_mode = MODE_ROUND;
   int mismatch_count = 0;
   int offered_count = 0;
   bit send_burst = 1'b0;

   // mode, first x/y, second x/y, known, weight
   pair_row_type directed_rows [N_DIRECTED] = '{
      '{MODE_ROUND, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 25'd0},
      '{MODE_ROUND, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, 25'd0},
      '{MODE_ROUND, C_3, C_4, 32'd0, 32'd0, 1'b1, 25'd5},
      '{MODE_ROUND, C_NEG3, C_NEG4, 32'd0, 32'd0, 1'b1, 25'd5},
      '{MODE_ROUND, C_HALF, 32'd0, 32'd0, 32'd0, 1'b1, 25'd1},
      '{MODE_ROUND, C_HALF - 1, 32'd0, 32'd0, 32'd0, 1'b1, 25'd0},
      '{MODE_ROUND, C_MIN, 32'd0, C_MAX, 32'd0, 1'b1, 25'd16777216},
      '{MODE_ROUND, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, 25'd0},
      '{MODE_ROUND, C_MAX, C_MIN, C_MIN, C_MAX, 1'b0, 25'd0},
      '{MODE_CEIL, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 25'd0},
      '{MODE_CEIL, C_3, C_4, 32'd0, 32'd0, 1'b1, 25'd5},
      '{MODE_CEIL, C_ULP, 32'd0, 32'd0, 32'd0, 1'b1, 25'd1},
      '{MODE_CEIL, 32'd257, 32'd0, 32'd0, 32'd0, 1'b1, 25'd2},
      '{MODE_CEIL, C_MIN, 32'd0, C_MAX, 32'd0, 1'b1, 25'd16777216},
      '{MODE_ATT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 25'd0},
      '{MODE_ATT, C_3, C_4, 32'd0, 32'd0, 1'b1, 25'd2},
      '{MODE_ATT, C_ULP, 32'd0, 32'd0, 32'd0, 1'b1, 25'd1},
      '{MODE_ATT, C_TEN, 32'd0, 32'd0, 32'd0, 1'b1, 25'd4},
      '{MODE_ATT, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, 25'd0},
      '{MODE_SPARE, C_3, C_4, 32'd0, 32'd0, 1'b1, 25'd5},
      '{MODE_SPARE, C_HALF, 32'd0, 32'd0, 32'd0, 1'b1, 25'd1}
   };

   tsp_edge_distance_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [127:0] root_floor(input logic [127:0] v);
      logic [127:0] rest;
      logic [127:0] acc;
      logic [127:0] probe;
      rest = v;
      acc = '0;
      probe = 128'd1 << 126;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= acc + probe) begin
            rest = rest - (acc + probe);
            acc = (acc >> 1) + probe;
         end else begin
            acc = acc >> 1;
         end
         probe = probe >> 2;
      end
      return acc;
   endfunction

   function automatic logic [127:0] coord_gap(input logic [COORD_WIDTH-1:0] a,
                                              input logic [COORD_WIDTH-1:0] b);
      logic signed [COORD_WIDTH:0] d;
      d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
      if (d < 0) d = -d;
      return {{(127-COORD_WIDTH){1'b0}}, d};
   endfunction

   function automatic logic [WEIGHT_WIDTH-1:0] predict_weight(
         input logic [1:0] mode,
         input logic [COORD_WIDTH-1:0] ax, ay, bx, by);
      logic [127:0] dx;
      logic [127:0] dy;
      logic [127:0] sum_sq;
      logic [127:0] radicand;
      logic [127:0] root;
      dx = coord_gap(ax, bx);
      dy = coord_gap(ay, by);
      sum_sq = dx * dx + dy * dy;
      if (mode == MODE_CEIL || mode == MODE_ATT) begin
         radicand = (sum_sq >> (2 * COORD_FRAC_BITS))
                  + ((sum_sq[2*COORD_FRAC_BITS-1:0] != 0) ? 128'd1 : 128'd0);
         if (mode == MODE_ATT) begin
            radicand = radicand / ATT_SCALE + ((radicand % ATT_SCALE != 0) ? 128'd1 : 128'd0);
         end
         root = root_floor(radicand);
         if (root * root != radicand) root = root + 1;
      end else begin
         // mode 3 falls back to rounded
         root = (root_floor(sum_sq << 2) + (128'd1 << COORD_FRAC_BITS))
              >> (COORD_FRAC_BITS + 1);
      end
      if (root > WEIGHT_MAX) root = WEIGHT_MAX;
      return root[WEIGHT_WIDTH-1:0];
   endfunction

   function automatic logic [COORD_WIDTH-1:0] corner_coord();
      case ($urandom_range(0, 3))
         0: return C_MIN;
         1: return C_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   task automatic draw_pair(output logic [COORD_WIDTH-1:0] ax, ay, bx, by);
      int kind;
      kind = $urandom_range(0, 9);
      ax = $urandom;
      ay = $urandom;
      bx = $urandom;
      by = $urandom;
      if (kind >= 4 && kind <= 6) begin
         bx = ax + COORD_WIDTH'($urandom_range(0, 8192) - 4096);
         by = ay + COORD_WIDTH'($urandom_range(0, 8192) - 4096);
      end else if (kind == 7) begin
         ax = COORD_WIDTH'($urandom_range(0, 4095) - 2048);
         ay = COORD_WIDTH'($urandom_range(0, 4095) - 2048);
         bx = COORD_WIDTH'($urandom_range(0, 4095) - 2048);
         by = COORD_WIDTH'($urandom_range(0, 4095) - 2048);
      end else if (kind == 8) begin
         bx = ax;
         by = ay;
      end else if (kind == 9) begin
         ax = corner_coord();
         ay = corner_coord();
         bx = corner_coord();
         by = corner_coord();
      end
   endtask

   // entered and left on a falling edge
   task automatic offer_pair(input logic [COORD_WIDTH-1:0] ax, ay, bx, by,
                             input bit known, input logic [WEIGHT_WIDTH-1:0] weight);
      int gap;
      if (offered_count % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
      gap = send_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_TDATA_W'({by, bx, ay, ax});
      do @(posedge clock); while (!req_tready);
      weight_queue.push_back(known ? weight : predict_weight(cur_mode, ax, ay, bx, by));
      offered_count++;
      @(negedge clock);
   endtask

   task automatic switch_mode(input logic [1:0] mode);
      req_tvalid <= 1'b0;
      while (weight_queue.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      cur_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [COORD_WIDTH-1:0] ax, ay, bx, by;
      logic [1:0] mode;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].mode != cur_mode) switch_mode(directed_rows[i].mode);
         offer_pair(directed_rows[i].ax, directed_rows[i].ay, directed_rows[i].bx,
                    directed_rows[i].by, directed_rows[i].known, directed_rows[i].weight);
      end
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0, 4: mode = MODE_ATT;
            1: mode = MODE_ROUND;
            3: mode = MODE_SPARE;
            default: mode = MODE_CEIL;
         endcase
         switch_mode(mode);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            draw_pair(ax, ay, bx, by);
            offer_pair(ax, ay, bx, by, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
      while (weight_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      int gap;
      int results_seen;
      bit take_burst;
      bit held;
      logic [WEIGHT_WIDTH-1:0] want;
      results_seen = 0;
      take_burst = 1'b0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (results_seen % 32 == 0) take_burst = ($urandom_range(0, 3) == 0);
         gap = take_burst ? 0 : $urandom_range(0, 8);
         // long hold-off so the pipeline backs up and req_tready drops
         if (results_seen == HOLD_AT_RESULT && !held) begin
            gap = LONG_HOLD;
            held = 1'b1;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         if (weight_queue.size() == 0) begin
            $error("edge_weight: no transaction pending, actual %0d",
                   rsp_tdata[WEIGHT_WIDTH-1:0]);
            mismatch_count++;
         end else begin
            want = weight_queue.pop_front();
            if (rsp_tdata[WEIGHT_WIDTH-1:0] !== want) begin
               $error("edge_weight: expected %0d, actual %0d",
                      want, rsp_tdata[WEIGHT_WIDTH-1:0]);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/ted_pkg.sv
sv/tsp_edge_distance_unit.sv
tb/sv/tsp_edge_distance_unit_tb.sv
